[hdl/obd_pvd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pvd_pkg
// Shared types and constants of the OBD-II PID value decoder.
// ----------------------------------------------------------------------------
package obd_pvd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;

    // default queue depths
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // operand source codes
    localparam logic [2:0] SRC_ZERO = 3'd0;
    localparam logic [2:0] SRC_A    = 3'd1;
    localparam logic [2:0] SRC_B    = 3'd2;
    localparam logic [2:0] SRC_W    = 3'd3;
    localparam logic [2:0] SRC_SW   = 3'd4;
    localparam logic [2:0] SRC_ABCD = 3'd5;

    // post-scaling operation codes
    localparam logic [1:0] POST_PASS  = 2'd0;
    localparam logic [1:0] POST_RECIP = 2'd1;
    localparam logic [1:0] POST_SHIFT = 2'd2;

    // constant division as multiply by ceil(2^33 / d), exact for numerators below 2^23
    localparam int RECIP_W     = 29;
    localparam int RECIP_NUM_W = 23;
    localparam int RECIP_SHIFT = 33;
    localparam int RECIP_PROD_W = RECIP_W + RECIP_NUM_W;
    localparam int QUOT_W      = RECIP_PROD_W - RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP_20   = 29'd429496730;
    localparam logic [RECIP_W-1:0] RECIP_100  = 29'd85899346;
    localparam logic [RECIP_W-1:0] RECIP_255  = 29'd33686019;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd8589935;

    localparam int MUL_W   = 7;
    localparam int OFS_W   = 16;
    localparam int SHAMT_W = 4;

    // per-item control decoded from the pid
    typedef struct packed {
        logic                     known;
        logic [2:0]               src;
        logic [MUL_W-1:0]         mul;
        logic signed [OFS_W-1:0]  ofs;
        logic [1:0]               post;
        logic [RECIP_W-1:0]       recip;
        logic [SHAMT_W-1:0]       shamt;
    } desc_t;

    // item as it sits in the queue between front and back
    typedef struct packed {
        desc_t             desc;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
    } work_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               known;
    } result_t;

endpackage

[hdl/obd_pvd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pvd_fifo
// Small register-based queue with full and empty flags.
// ----------------------------------------------------------------------------
module obd_pvd_fifo
    import obd_pvd_pkg::*;
#(
    parameter int DEPTH = MID_DEPTH_DEF,
    parameter int WIDTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[hdl/obd_pvd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pvd_front
// Classifies each pid into an operand source, scale, offset and post-op.
// ----------------------------------------------------------------------------
module obd_pvd_front
    import obd_pvd_pkg::*;
(
    input  logic [BYTE_W-1:0] pid,
    output desc_t             desc
);

    function automatic desc_t mk(
        input logic                    known,
        input logic [2:0]              src,
        input logic [MUL_W-1:0]        mul,
        input logic signed [OFS_W-1:0] ofs,
        input logic [1:0]              post,
        input logic [RECIP_W-1:0]      recip,
        input logic [SHAMT_W-1:0]      shamt
    );
        desc_t r;
        r.known = known;
        r.src   = src;
        r.mul   = mul;
        r.ofs   = ofs;
        r.post  = post;
        r.recip = recip;
        r.shamt = shamt;
        return r;
    endfunction

    always_comb
    begin
        unique case (pid) inside
            8'h01, 8'h02, 8'h41:
                desc = mk(1'b1, SRC_ABCD, 7'd1, 16'sd0, POST_PASS, '0, 4'd0);
            8'h03, 8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E:
                desc = mk(1'b1, SRC_W, 7'd1, 16'sd0, POST_PASS, '0, 4'd0);
            8'h05, 8'h0F, 8'h46, 8'h5C:
                desc = mk(1'b1, SRC_A, 7'd1, -16'sd40, POST_PASS, '0, 4'd0);
            8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, [8'h47:8'h4C], 8'h52,
            8'h5A, 8'h5B:
                desc = mk(1'b1, SRC_A, 7'd100, 16'sd0, POST_RECIP, RECIP_255, 4'd0);
            8'h0B, 8'h0D, 8'h12, 8'h13, 8'h1C, 8'h1D, 8'h1E, 8'h30, 8'h33, 8'h51:
                desc = mk(1'b1, SRC_A, 7'd1, 16'sd0, POST_PASS, '0, 4'd0);
            [8'h06:8'h09], 8'h2D:
                desc = mk(1'b1, SRC_A, 7'd100, -16'sd12800, POST_SHIFT, '0, 4'd7);
            [8'h14:8'h1B]:
                desc = mk(1'b1, SRC_B, 7'd100, -16'sd12800, POST_SHIFT, '0, 4'd7);
            8'h0A:
                desc = mk(1'b1, SRC_A, 7'd3, 16'sd0, POST_PASS, '0, 4'd0);
            8'h0C:
                desc = mk(1'b1, SRC_W, 7'd1, 16'sd0, POST_SHIFT, '0, 4'd2);
            8'h0E:
                desc = mk(1'b1, SRC_A, 7'd1, -16'sd128, POST_SHIFT, '0, 4'd1);
            8'h10:
                desc = mk(1'b1, SRC_W, 7'd1, 16'sd0, POST_RECIP, RECIP_100, 4'd0);
            8'h22:
                desc = mk(1'b1, SRC_W, 7'd79, 16'sd0, POST_RECIP, RECIP_1000, 4'd0);
            8'h23, 8'h59:
                desc = mk(1'b1, SRC_W, 7'd10, 16'sd0, POST_PASS, '0, 4'd0);
            [8'h24:8'h2B]:
                desc = mk(1'b1, SRC_W, 7'd1, 16'sd0, POST_SHIFT, '0, 4'd15);
            8'h32:
                desc = mk(1'b1, SRC_SW, 7'd1, 16'sd0, POST_SHIFT, '0, 4'd2);
            8'h42:
                desc = mk(1'b1, SRC_W, 7'd1, 16'sd0, POST_RECIP, RECIP_1000, 4'd0);
            8'h43:
                desc = mk(1'b1, SRC_W, 7'd100, 16'sd0, POST_RECIP, RECIP_255, 4'd0);
            8'h5D:
                desc = mk(1'b1, SRC_W, 7'd1, -16'sd26880, POST_SHIFT, '0, 4'd7);
            8'h5E:
                desc = mk(1'b1, SRC_W, 7'd1, 16'sd0, POST_RECIP, RECIP_20, 4'd0);
            default:
                desc = mk(1'b0, SRC_ZERO, 7'd1, 16'sd0, POST_PASS, '0, 4'd0);
        endcase
    end

endmodule

[hdl/obd_pvd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pvd_back
// Scales the selected operand, registers it, then applies the constant divide.
// ----------------------------------------------------------------------------
module obd_pvd_back
    import obd_pvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  work_t   in_item,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_res,
    input  logic    out_ready
);

    localparam int X_W     = 2 * BYTE_W + 2;
    localparam int SCALE_W = X_W + MUL_W + 1;

    logic                      valid_reg;
    logic [VALUE_W-1:0]        num_reg;
    logic [1:0]                post_reg;
    logic [RECIP_W-1:0]        recip_reg;
    logic [SHAMT_W-1:0]        shamt_reg;
    logic                      known_reg;

    logic signed [X_W-1:0]     x;
    logic signed [SCALE_W-1:0] scaled;
    logic [VALUE_W-1:0]        num_next;
    logic                      advance;

    logic [RECIP_PROD_W-1:0]   prod;
    logic [VALUE_W-1:0]        bias;
    logic signed [VALUE_W-1:0] biased;
    logic [VALUE_W-1:0]        value;

    // stage 1: operand times scale plus offset, or A:B:C:D taken raw
    always_comb
    begin
        unique case (in_item.desc.src)
            SRC_A:   x = X_W'({1'b0, in_item.a});
            SRC_B:   x = X_W'({1'b0, in_item.b});
            SRC_W:   x = X_W'({1'b0, in_item.a, in_item.b});
            SRC_SW:  x = X_W'($signed({in_item.a, in_item.b}));
            default: x = '0;
        endcase
        scaled = SCALE_W'(x) * SCALE_W'($signed({1'b0, in_item.desc.mul}));
        if (in_item.desc.src == SRC_ABCD)
        begin
            num_next = {in_item.a, in_item.b, in_item.c, in_item.d};
        end
        else
        begin
            num_next = VALUE_W'(scaled) + VALUE_W'(in_item.desc.ofs);
        end
    end

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            num_reg   <= num_next;
            post_reg  <= in_item.desc.post;
            recip_reg <= in_item.desc.recip;
            shamt_reg <= in_item.desc.shamt;
            known_reg <= in_item.desc.known;
        end
    end

    // stage 2: divide by constant, either reciprocal or shift toward zero, or pass through
    always_comb
    begin
        prod   = RECIP_PROD_W'(num_reg[RECIP_NUM_W-1:0]) * RECIP_PROD_W'(recip_reg);
        bias   = num_reg[VALUE_W-1] ? ((VALUE_W'(1) << shamt_reg) - 1'b1) : '0;
        biased = $signed(num_reg + bias);
        case (post_reg)
            POST_RECIP: value = VALUE_W'(prod[RECIP_PROD_W-1:RECIP_SHIFT]);
            POST_SHIFT: value = VALUE_W'(biased >>> shamt_reg);
            default:    value = num_reg;
        endcase
    end

    assign out_res.value = value;
    assign out_res.known = known_reg;

endmodule

[hdl/obd_pid_value_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pid_value_decode
// OBD-II mode 01 PID value decoder with queue interfaces on both sides.
// ----------------------------------------------------------------------------
// Each item carries a pid and the response bytes A to D; the result is the
// signed engineering value (truncated toward zero) plus a flag that is low for
// pids without a formula, which then give 0. Bitmask pids return A:B:C:D raw.
// One item is accepted per clock cycle for as long as results are popped; a
// result passes the input queue, the scaling multiplier register and the
// output queue before it shows on the result ports and can be popped. full
// rises only when both queues and the scaling stage hold items that the
// consumer has not taken.
// ----------------------------------------------------------------------------
module obd_pid_value_decode
    import obd_pvd_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [BYTE_W-1:0]         pid,
    input  logic [BYTE_W-1:0]         byte_a,
    input  logic [BYTE_W-1:0]         byte_b,
    input  logic [BYTE_W-1:0]         byte_c,
    input  logic [BYTE_W-1:0]         byte_d,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] value,
    output logic                      pid_known
);

    desc_t   desc;
    work_t   mid_din;
    work_t   mid_dout;
    logic    mid_empty;
    logic    mid_pop;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    out_full;

    obd_pvd_front u_front
    (
        .pid  (pid),
        .desc (desc)
    );

    assign mid_din.desc = desc;
    assign mid_din.a    = byte_a;
    assign mid_din.b    = byte_b;
    assign mid_din.c    = byte_c;
    assign mid_din.d    = byte_d;

    obd_pvd_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(work_t))
    ) u_mid_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (mid_din),
        .full  (full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    obd_pvd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_item   (mid_dout),
        .in_ready  (mid_pop),
        .out_valid (res_valid),
        .out_res   (res),
        .out_ready (!out_full)
    );

    obd_pvd_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_out_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .din   (res),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign value     = $signed(out_res.value);
    assign pid_known = out_res.known;

endmodule
